// ===== rtl/mfp_pkg.sv =====
`timescale 1ns / 1ps
// mfp_pkg: shared types, codes and the CRC-16/MCRF4XX byte step for the
// MAVLink frame parser. No dependencies.
package mfp_pkg;

  // Payload bytes that decoding ever reads (RAW_IMU ends at byte 25)
  localparam int DecodeBytes = 26;
  localparam int StoreIdxW   = $clog2(DecodeBytes);

  // Start bytes
  localparam logic [7:0] StartV1 = 8'hFE;
  localparam logic [7:0] StartV2 = 8'hFD;

  localparam logic [15:0] CrcSeed = 16'hFFFF;

  // Message IDs that decode
  localparam logic [23:0] MsgHeartbeat = 24'd0;
  localparam logic [23:0] MsgRawImu    = 24'd27;

  // Register reset values
  localparam logic [7:0] ExtraHeartbeatRst = 8'd50;
  localparam logic [7:0] ExtraRawImuRst    = 8'd144;

  // Configuration register indexes
  localparam logic CfgExtraHeartbeat = 1'b0;
  localparam logic CfgExtraRawImu    = 1'b1;

  // Record kinds
  localparam logic [1:0] KindHeartbeat = 2'd0;
  localparam logic [1:0] KindAccel     = 2'd1;
  localparam logic [1:0] KindGyro      = 2'd2;
  localparam logic [1:0] KindMag       = 2'd3;

  // Decoded frame handed from parser to emitter
  typedef struct packed {
    logic             vld;
    logic             is_imu;
    logic             armed;
    logic [8:0][15:0] val;   // imu: accel xyz, gyro xyz, mag xyz; hb: type, autopilot, mode
  } mfp_frame_t;

  // One result record
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] msg_id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        armed;
    logic        last;
  } mfp_record_t;

  // One CRC-16/MCRF4XX step over a byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ===== rtl/mfp_parser.sv =====
`timescale 1ns / 1ps
// mfp_parser: header walk, running CRC, payload capture and frame check.
// Depends on mfp_pkg.
module mfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          extra_hb,
  input  logic [7:0]          extra_imu,
  output logic                at_ck1,
  output mfp_pkg::mfp_frame_t frame
);

  typedef enum logic [3:0] {
    PH_START, PH_LEN, PH_INCOMP, PH_COMPAT, PH_SEQ, PH_SYS, PH_COMP,
    PH_ID0, PH_ID1, PH_ID2, PH_PAYLOAD, PH_CK0, PH_CK1
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        v2_r, v2_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  ck_lo_r, ck_lo_nxt;
  logic [23:0] id_r, id_nxt;
  logic [7:0]  store_r [mfp_pkg::DecodeBytes];

  logic [15:0] crc_in;
  logic [7:0]  extra;
  logic [15:0] crc_fin;
  logic        crc_ok;
  logic        known_id;
  logic        is_imu;
  logic [7:0]  pb [mfp_pkg::DecodeBytes];

  assign crc_in = mfp_pkg::crc_step(crc_r, rx_byte);
  assign at_ck1 = (phase_r == PH_CK1);

  // Advance the header walk
  always_comb begin
    phase_nxt = phase_r;
    v2_nxt    = v2_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    ck_lo_nxt = ck_lo_r;
    id_nxt    = id_r;
    case (phase_r)
      PH_START: begin
        if (rx_byte == mfp_pkg::StartV1 || rx_byte == mfp_pkg::StartV2) begin
          v2_nxt    = (rx_byte == mfp_pkg::StartV2);
          crc_nxt   = mfp_pkg::CrcSeed;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_nxt   = crc_in;
        len_nxt   = rx_byte;
        phase_nxt = v2_r ? PH_INCOMP : PH_SEQ;
      end
      PH_INCOMP: begin
        // drop v2 frames with incompatibility flags set
        crc_nxt   = crc_in;
        phase_nxt = (rx_byte != 8'h00) ? PH_START : PH_COMPAT;
      end
      PH_COMPAT: begin
        crc_nxt   = crc_in;
        phase_nxt = PH_SEQ;
      end
      PH_SEQ: begin
        crc_nxt   = crc_in;
        phase_nxt = PH_SYS;
      end
      PH_SYS: begin
        crc_nxt   = crc_in;
        phase_nxt = PH_COMP;
      end
      PH_COMP: begin
        crc_nxt   = crc_in;
        phase_nxt = PH_ID0;
      end
      PH_ID0: begin
        crc_nxt = crc_in;
        id_nxt  = {16'h0000, rx_byte};
        idx_nxt = 8'h00;
        if (v2_r) begin
          phase_nxt = PH_ID1;
        end else begin
          phase_nxt = (len_r != 8'h00) ? PH_PAYLOAD : PH_CK0;
        end
      end
      PH_ID1: begin
        crc_nxt   = crc_in;
        id_nxt    = {id_r[23:16], rx_byte, id_r[7:0]};
        phase_nxt = PH_ID2;
      end
      PH_ID2: begin
        crc_nxt   = crc_in;
        id_nxt    = {rx_byte, id_r[15:0]};
        phase_nxt = (len_r != 8'h00) ? PH_PAYLOAD : PH_CK0;
      end
      PH_PAYLOAD: begin
        crc_nxt = crc_in;
        idx_nxt = idx_r + 8'd1;
        if (idx_nxt >= len_r) begin
          phase_nxt = PH_CK0;
        end
      end
      PH_CK0: begin
        ck_lo_nxt = rx_byte;
        phase_nxt = PH_CK1;
      end
      PH_CK1: begin
        phase_nxt = PH_START;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      v2_r    <= 1'b0;
      len_r   <= 8'h00;
      idx_r   <= 8'h00;
      crc_r   <= mfp_pkg::CrcSeed;
      ck_lo_r <= 8'h00;
      id_r    <= 24'h000000;
    end else if (accept) begin
      phase_r <= phase_nxt;
      v2_r    <= v2_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      ck_lo_r <= ck_lo_nxt;
      id_r    <= id_nxt;
    end
  end

  // Keep only the payload bytes that decoding reads; later bytes feed the CRC only
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_PAYLOAD &&
        idx_r < 8'(mfp_pkg::DecodeBytes)) begin
      store_r[idx_r[mfp_pkg::StoreIdxW-1:0]] <= rx_byte;
    end
  end

  // Bytes past the received length read as zero
  always_comb begin
    for (int i = 0; i < mfp_pkg::DecodeBytes; i++) begin
      pb[i] = (8'(i) < len_r) ? store_r[i] : 8'h00;
    end
  end

  // Fold in the per-message extra byte and compare with the received checksum
  always_comb begin
    if (id_r == mfp_pkg::MsgHeartbeat) begin
      extra = extra_hb;
    end else if (id_r == mfp_pkg::MsgRawImu) begin
      extra = extra_imu;
    end else begin
      extra = 8'h00;
    end
  end

  assign crc_fin  = mfp_pkg::crc_step(crc_r, extra);
  assign crc_ok   = ({rx_byte, ck_lo_r} == crc_fin);
  assign is_imu   = (id_r == mfp_pkg::MsgRawImu);
  assign known_id = is_imu || (id_r == mfp_pkg::MsgHeartbeat);

  // Decode the payload of a checked frame
  always_comb begin
    frame.vld    = accept && at_ck1 && crc_ok && known_id;
    frame.is_imu = is_imu;
    frame.armed  = !is_imu && pb[6][7];
    for (int k = 0; k < 9; k++) begin
      if (is_imu) begin
        frame.val[k] = {pb[9 + 2*k], pb[8 + 2*k]};
      end else if (k < 3) begin
        frame.val[k] = {8'h00, pb[4 + k]};
      end else begin
        frame.val[k] = 16'h0000;
      end
    end
  end

endmodule

// ===== rtl/mfp_emitter.sv =====
`timescale 1ns / 1ps
// mfp_emitter: result register for one decoded frame, sends its records in order.
// Depends on mfp_pkg.
module mfp_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfp_pkg::mfp_frame_t  frame,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mfp_pkg::mfp_record_t rec
);

  logic             busy_r;
  logic [1:0]       idx_r;
  logic             is_imu_r;
  logic             armed_r;
  logic [8:0][15:0] val_r;

  assign busy      = busy_r;
  assign out_valid = busy_r;

  // Load a new frame, advance on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (frame.vld) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (busy_r && out_ready) begin
      if (rec.last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Hold the decoded payload
  always_ff @(posedge clk) begin
    if (frame.vld) begin
      is_imu_r <= frame.is_imu;
      armed_r  <= frame.armed;
      val_r    <= frame.val;
    end
  end

  // Select the current record
  always_comb begin
    rec.msg_id = is_imu_r ? mfp_pkg::MsgRawImu : mfp_pkg::MsgHeartbeat;
    rec.armed  = !is_imu_r && armed_r;
    case (idx_r)
      2'd0: begin
        rec.kind = is_imu_r ? mfp_pkg::KindAccel : mfp_pkg::KindHeartbeat;
        rec.x    = val_r[0];
        rec.y    = val_r[1];
        rec.z    = val_r[2];
        rec.last = !is_imu_r;
      end
      2'd1: begin
        rec.kind = mfp_pkg::KindGyro;
        rec.x    = val_r[3];
        rec.y    = val_r[4];
        rec.z    = val_r[5];
        rec.last = 1'b0;
      end
      2'd2: begin
        rec.kind = mfp_pkg::KindMag;
        rec.x    = val_r[6];
        rec.y    = val_r[7];
        rec.z    = val_r[8];
        rec.last = 1'b1;
      end
      default: begin
        rec.kind = mfp_pkg::KindMag;
        rec.x    = val_r[6];
        rec.y    = val_r[7];
        rec.z    = val_r[8];
        rec.last = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/mavlink_frame_parser.sv =====
`timescale 1ns / 1ps
// mavlink_frame_parser: top level of the MAVLink v1/v2 frame parser and decoder.
// Depends on mfp_pkg, mfp_parser and mfp_emitter.
//
//  channel  direction  payload                                  item
//  in_      slave      tdata = rx_byte                          one received byte
//  out_     master     tdata/tuser/tlast = one decoded record   one record
//  cfg_     write      cfg_addr 0 extra_heartbeat, 1 raw_imu    one register write
//
// One byte is taken per cycle while in_tready is high; the CRC step and header walk
// finish in the cycle after acceptance; a frame's records appear in the cycle after its
// last checksum byte, one per cycle while out_tready is high (1 HEARTBEAT, 3 RAW_IMU).
// Reset (rst_n low, synchronous) returns to start-byte hunting and restores the
// CRC extra bytes to 50 and 144.
// in_tready drops only while a second checksum byte waits and the previous
// frame's records are still held by a stalled output.
module mavlink_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [23:0] message_id, [39:24] value_x, [55:40] value_y,
                                  // [71:56] value_z, [72] armed, [79:73] zero
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast,  // last_record
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]           extra_hb_val_r;
  logic [7:0]           extra_imu_r;
  logic                 accept;
  logic                 at_ck1;
  logic                 busy;
  mfp_pkg::mfp_frame_t  frame;
  mfp_pkg::mfp_record_t rec;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_hb_val_r <= mfp_pkg::ExtraHeartbeatRst;
      extra_imu_r    <= mfp_pkg::ExtraRawImuRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        mfp_pkg::CfgExtraHeartbeat: extra_hb_val_r <= cfg_wdata;
        mfp_pkg::CfgExtraRawImu:    extra_imu_r    <= cfg_wdata;
        default: begin
          extra_imu_r <= extra_imu_r;
        end
      endcase
    end
  end

  // Stall only a frame end that would overwrite undelivered records
  assign in_tready = !(at_ck1 && busy);
  assign accept    = in_tvalid && in_tready;

  mfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .extra_hb  (extra_hb_val_r),
    .extra_imu (extra_imu_r),
    .at_ck1    (at_ck1),
    .frame     (frame)
  );

  mfp_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .busy      (busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rec       (rec)
  );

  // Pack the record onto the output bus
  assign out_tdata = {7'b0000000, rec.armed, rec.z, rec.y, rec.x, rec.msg_id};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule

// ===== sim/tb_mavlink_frame_parser.sv =====
`timescale 1ns / 1ps
// tb_mavlink_frame_parser: self-checking bench for the MAVLink v1/v2 frame parser.
// Streams directed and random frames with random idle, predicts records in a tracker
// class and checks every output record. Depends on mfp_pkg and mavlink_frame_parser.

// Tracks the parser state byte by byte and holds the records still owed
class decode_tracker;
  typedef enum logic [3:0] {
    P_HUNT, P_LEN, P_INCOMPAT, P_COMPAT, P_SEQ, P_SYS, P_COMP,
    P_ID0, P_ID1, P_ID2, P_PAYLOAD, P_CK0, P_CK1
  } parse_step_t;

  mfp_pkg::mfp_record_t expected_records[$];
  logic [7:0]  extra_hb;
  logic [7:0]  extra_imu;
  parse_step_t step;
  bit          v2;
  logic [7:0]  frame_len;
  logic [7:0]  pay_idx;
  logic [7:0]  ck_lo;
  logic [7:0]  pay_store[64];
  logic [15:0] crc;
  logic [23:0] msg_id;
  int          mismatches;
  int          predicted;

  function new();
    extra_hb   = mfp_pkg::ExtraHeartbeatRst;
    extra_imu  = mfp_pkg::ExtraRawImuRst;
    step       = P_HUNT;
    v2         = 1'b0;
    frame_len  = 8'h00;
    pay_idx    = 8'h00;
    ck_lo      = 8'h00;
    crc        = mfp_pkg::CrcSeed;
    msg_id     = 24'h0;
    mismatches = 0;
    predicted  = 0;
  endfunction

  // Reflected CCITT polynomial, one bit at a time
  static function logic [15:0] crc_mcrf(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function void set_extra(input logic which, input logic [7:0] v);
    if (which == mfp_pkg::CfgExtraHeartbeat) extra_hb = v;
    else extra_imu = v;
  endfunction

  function bit hunting();
    return step == P_HUNT;
  endfunction

  // Bytes past the received length or the store read as zero
  function logic [7:0] stored(input int i);
    if (i < frame_len && i < 64) return pay_store[i];
    return 8'h00;
  endfunction

  function logic [15:0] word_at(input int i);
    return {stored(i + 1), stored(i)};
  endfunction

  function void add_record(input logic [1:0] kind, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic armed, input logic last);
    mfp_pkg::mfp_record_t r;
    r.kind   = kind;
    r.msg_id = msg_id;
    r.x      = x;
    r.y      = y;
    r.z      = z;
    r.armed  = armed;
    r.last   = last;
    expected_records.push_back(r);
    predicted++;
  endfunction

  // Advance the parser by one accepted byte
  function void take_byte(input logic [7:0] b);
    logic [7:0] extra;
    logic [7:0] base;
    case (step)
      P_HUNT: begin
        if (b == mfp_pkg::StartV1 || b == mfp_pkg::StartV2) begin
          v2   = (b == mfp_pkg::StartV2);
          crc  = mfp_pkg::CrcSeed;
          step = P_LEN;
        end
      end
      P_LEN: begin
        crc       = crc_mcrf(crc, b);
        frame_len = b;
        step      = v2 ? P_INCOMPAT : P_SEQ;
      end
      P_INCOMPAT: begin
        crc  = crc_mcrf(crc, b);
        step = (b != 8'h00) ? P_HUNT : P_COMPAT;
      end
      P_COMPAT, P_SEQ, P_SYS, P_COMP: begin
        crc  = crc_mcrf(crc, b);
        step = parse_step_t'(step + 1);
      end
      P_ID0: begin
        crc     = crc_mcrf(crc, b);
        msg_id  = {16'h0000, b};
        pay_idx = 8'h00;
        step    = v2 ? P_ID1 : ((frame_len != 8'h00) ? P_PAYLOAD : P_CK0);
      end
      P_ID1: begin
        crc          = crc_mcrf(crc, b);
        msg_id[15:8] = b;
        step         = P_ID2;
      end
      P_ID2: begin
        crc           = crc_mcrf(crc, b);
        msg_id[23:16] = b;
        step          = (frame_len != 8'h00) ? P_PAYLOAD : P_CK0;
      end
      P_PAYLOAD: begin
        crc = crc_mcrf(crc, b);
        if (pay_idx < 64) pay_store[pay_idx[5:0]] = b;
        pay_idx = pay_idx + 8'd1;
        if (pay_idx >= frame_len) step = P_CK0;
      end
      P_CK0: begin
        ck_lo = b;
        step  = P_CK1;
      end
      P_CK1: begin
        if (msg_id == mfp_pkg::MsgHeartbeat) extra = extra_hb;
        else if (msg_id == mfp_pkg::MsgRawImu) extra = extra_imu;
        else extra = 8'h00;
        // Decode only on a matching checksum
        if ({b, ck_lo} == crc_mcrf(crc, extra)) begin
          if (msg_id == mfp_pkg::MsgHeartbeat) begin
            base = stored(6);
            add_record(mfp_pkg::KindHeartbeat, {8'h00, stored(4)}, {8'h00, stored(5)},
                       {8'h00, base}, base[7], 1'b1);
          end else if (msg_id == mfp_pkg::MsgRawImu) begin
            add_record(mfp_pkg::KindAccel, word_at(8), word_at(10), word_at(12), 1'b0, 1'b0);
            add_record(mfp_pkg::KindGyro, word_at(14), word_at(16), word_at(18), 1'b0, 1'b0);
            add_record(mfp_pkg::KindMag, word_at(20), word_at(22), word_at(24), 1'b0, 1'b1);
          end
        end
        step = P_HUNT;
      end
      default: step = P_HUNT;
    endcase
  endfunction

  function void check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one output record with the oldest one owed
  function void match_record(input mfp_pkg::mfp_record_t got);
    mfp_pkg::mfp_record_t want;
    if (expected_records.size() == 0) begin
      $error("record with none expected: kind %0d, message_id %0h", got.kind, got.msg_id);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    check_field("record_kind", want.kind, got.kind);
    check_field("message_id", want.msg_id, got.msg_id);
    check_field("value_x", want.x, got.x);
    check_field("value_y", want.y, got.y);
    check_field("value_z", want.z, got.z);
    check_field("armed", want.armed, got.armed);
    check_field("last_record", want.last, got.last);
  endfunction
endclass

module tb_mavlink_frame_parser;

  typedef logic [7:0] octet_q_t[$];

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b1;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = mfp_pkg::CfgExtraHeartbeat;
  logic [7:0]  cfg_wdata  = 8'h00;
  wire         in_tready;
  wire         out_tvalid;
  wire  [79:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  decode_tracker tracker = new();

  bit         no_idle       = 1'b0;
  int         ready_hold    = 0;
  int         cycles        = 0;
  int         bytes_sent    = 0;
  logic [7:0] extra_hb_now  = mfp_pkg::ExtraHeartbeatRst;
  logic [7:0] extra_imu_now = mfp_pkg::ExtraRawImuRst;

  mavlink_frame_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Check accepted records and, unless no_idle is set, at random stall the result side after one
  always @(posedge clk) begin
    mfp_pkg::mfp_record_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.msg_id = out_tdata[23:0];
      got.x      = out_tdata[39:24];
      got.y      = out_tdata[55:40];
      got.z      = out_tdata[71:56];
      got.armed  = out_tdata[72];
      got.last   = out_tlast;
      tracker.match_record(got);
    end
    if (ready_hold > 0) begin
      ready_hold--;
      if (ready_hold == 0) out_tready <= 1'b1;
    end else if (rst_n && out_tvalid && out_tready) begin
      ready_hold = no_idle ? 0 : $urandom_range(0, 4);
      if (ready_hold > 0) out_tready <= 1'b0;
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_mavlink_frame_parser: errors");
    $finish;
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  // Build a frame with a correct (or corrupted) checksum; cut > 0 sends only a prefix
  task automatic send_frame(input bit v2, input logic [7:0] incompat, input logic [23:0] id,
                            input octet_q_t body, input bit corrupt, input int cut);
    octet_q_t    bytes;
    logic [15:0] crc;
    logic [15:0] sum;
    logic [7:0]  extra;
    int          n;
    if (!v2) id[23:8] = 16'h0000;
    bytes.push_back(v2 ? mfp_pkg::StartV2 : mfp_pkg::StartV1);
    bytes.push_back(8'(body.size()));
    if (v2) begin
      bytes.push_back(incompat);
      bytes.push_back(8'($urandom));
    end
    repeat (3) bytes.push_back(8'($urandom));
    bytes.push_back(id[7:0]);
    if (v2) begin
      bytes.push_back(id[15:8]);
      bytes.push_back(id[23:16]);
    end
    foreach (body[k]) bytes.push_back(body[k]);
    crc = mfp_pkg::CrcSeed;
    for (int k = 1; k < bytes.size(); k++) crc = tracker.crc_mcrf(crc, bytes[k]);
    if (id == mfp_pkg::MsgHeartbeat) extra = extra_hb_now;
    else if (id == mfp_pkg::MsgRawImu) extra = extra_imu_now;
    else extra = 8'h00;
    sum = tracker.crc_mcrf(crc, extra);
    if (corrupt) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    bytes.push_back(sum[7:0]);
    bytes.push_back(sum[15:8]);
    n = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
    for (int k = 0; k < n; k++) send_byte(bytes[k]);
  endtask

  // Payload bytes biased toward the extremes
  function automatic octet_q_t make_body(input int len);
    octet_q_t q;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       q.push_back(8'h00);
        1:       q.push_back(8'hFF);
        2:       q.push_back(8'h80);
        3:       q.push_back(8'h7F);
        default: q.push_back(8'($urandom));
      endcase
    end
    return q;
  endfunction

  // Feed filler until the parser is hunting again
  task automatic return_to_hunt();
    while (!tracker.hunting()) send_byte(8'h00);
  endtask

  // Wait until every owed record has come out, then let the block settle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.expected_records.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_extras(input logic [7:0] hb, input logic [7:0] imu);
    cfg_we    <= 1'b1;
    cfg_addr  <= mfp_pkg::CfgExtraHeartbeat;
    cfg_wdata <= hb;
    @(posedge clk);
    cfg_addr  <= mfp_pkg::CfgExtraRawImu;
    cfg_wdata <= imu;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_extra(mfp_pkg::CfgExtraHeartbeat, hb);
    tracker.set_extra(mfp_pkg::CfgExtraRawImu, imu);
    extra_hb_now  = hb;
    extra_imu_now = imu;
  endtask

  // Mostly good frames; also bad checksums, foreign IDs, dropped v2, cut frames, noise
  task automatic random_frame();
    int          pick;
    int          len;
    bit          v2;
    logic [23:0] id;
    pick    = $urandom_range(0, 99);
    v2      = $urandom_range(0, 1);
    no_idle = ($urandom_range(0, 4) == 0);
    if (pick < 40) begin
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : 9;
      send_frame(v2, 8'h00, mfp_pkg::MsgHeartbeat, make_body(len), 1'b0, 0);
    end else if (pick < 75) begin
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 80) : 26;
      send_frame(v2, 8'h00, mfp_pkg::MsgRawImu, make_body(len), 1'b0, 0);
    end else if (pick < 82) begin
      if ($urandom_range(0, 1)) begin
        send_frame(v2, 8'h00, mfp_pkg::MsgHeartbeat, make_body(9), 1'b1, 0);
      end else begin
        send_frame(v2, 8'h00, mfp_pkg::MsgRawImu, make_body(26), 1'b1, 0);
      end
    end else if (pick < 88) begin
      id = 24'($urandom);
      send_frame(v2, 8'h00, id, make_body($urandom_range(0, 30)), 1'b0, 0);
    end else if (pick < 93) begin
      send_frame(1'b1, 8'($urandom_range(1, 255)), mfp_pkg::MsgRawImu, make_body(26), 1'b0, 0);
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      send_frame(v2, 8'h00, mfp_pkg::MsgRawImu, make_body(26), 1'b0, $urandom_range(1, 20));
    end
  endtask

  initial begin
    octet_q_t body;
    int       phase_start;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Noise while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFC);
    send_byte(8'h55);
    send_byte(8'hAA);

    // Heartbeats, armed and not
    body = make_body(9);
    body[4] = 8'hFF;
    body[5] = 8'h00;
    body[6] = 8'h80;
    send_frame(1'b0, 8'h00, mfp_pkg::MsgHeartbeat, body, 1'b0, 0);
    body = make_body(9);
    body[6] = 8'h7F;
    send_frame(1'b1, 8'h00, mfp_pkg::MsgHeartbeat, body, 1'b0, 0);

    // Raw IMU with extreme axis values
    body = make_body(26);
    body[8]  = 8'h00;
    body[9]  = 8'h80;
    body[10] = 8'hFF;
    body[11] = 8'h7F;
    body[12] = 8'hFF;
    body[13] = 8'hFF;
    body[14] = 8'h00;
    body[15] = 8'h00;
    send_frame(1'b0, 8'h00, mfp_pkg::MsgRawImu, body, 1'b0, 0);
    send_frame(1'b1, 8'h00, mfp_pkg::MsgRawImu, make_body(26), 1'b0, 0);

    // Drop v2 frames with incompatibility flags
    send_frame(1'b1, 8'h01, mfp_pkg::MsgHeartbeat, make_body(9), 1'b0, 0);
    send_frame(1'b1, 8'h80, mfp_pkg::MsgRawImu, make_body(9), 1'b0, 0);

    // Bad checksums
    send_frame(1'b0, 8'h00, mfp_pkg::MsgHeartbeat, make_body(9), 1'b1, 0);
    send_frame(1'b1, 8'h00, mfp_pkg::MsgRawImu, make_body(26), 1'b1, 0);

    // IDs that do not decode, including upper ID bytes set
    send_frame(1'b0, 8'h00, 24'h000001, make_body(9), 1'b0, 0);
    send_frame(1'b1, 8'h00, 24'h01001B, make_body(9), 1'b0, 0);
    send_frame(1'b1, 8'h00, 24'h000100, make_body(9), 1'b0, 0);
    send_frame(1'b1, 8'h00, 24'hFFFFFF, make_body(4), 1'b0, 0);

    // Empty and short payloads decode with zero fill
    send_frame(1'b0, 8'h00, mfp_pkg::MsgHeartbeat, make_body(0), 1'b0, 0);
    send_frame(1'b1, 8'h00, mfp_pkg::MsgRawImu, make_body(0), 1'b0, 0);
    send_frame(1'b1, 8'h00, mfp_pkg::MsgRawImu, make_body(10), 1'b0, 0);
    send_frame(1'b0, 8'h00, mfp_pkg::MsgHeartbeat, make_body(5), 1'b0, 0);

    // Long payloads, the first one past the 64-byte store
    send_frame(1'b0, 8'h00, mfp_pkg::MsgHeartbeat, make_body(70), 1'b0, 0);
    send_frame(1'b1, 8'h00, mfp_pkg::MsgRawImu, make_body(40), 1'b0, 0);

    // Back to back with no idling
    no_idle = 1'b1;
    send_frame(1'b1, 8'h00, mfp_pkg::MsgHeartbeat, make_body(9), 1'b0, 0);
    send_frame(1'b0, 8'h00, mfp_pkg::MsgRawImu, make_body(26), 1'b0, 0);
    no_idle = 1'b0;
    return_to_hunt();
    settle();

    // Random frames under several checksum extra settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_extras(8'hFF, 8'hFF);
        1:       set_extras(8'h00, 8'h00);
        2, 3:    set_extras(8'($urandom), 8'($urandom));
        default: set_extras(mfp_pkg::ExtraHeartbeatRst, mfp_pkg::ExtraRawImuRst);
      endcase
      phase_start = bytes_sent;
      do random_frame(); while (bytes_sent - phase_start < 16);
      no_idle = 1'b0;
      return_to_hunt();
      settle();
    end

    if (tracker.mismatches == 0) begin
      $display("tb_mavlink_frame_parser: clean");
    end else begin
      $display("tb_mavlink_frame_parser: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mfp_pkg.sv
rtl/mfp_parser.sv
rtl/mfp_emitter.sv
rtl/mavlink_frame_parser.sv
sim/tb_mavlink_frame_parser.sv
